### rtl/mpfb_pkg.sv
// Shared constants, op codes and types for the masked packet filter bank.
// No dependencies.
package mpfb_pkg;

  localparam int FILTERS     = 4;
  localparam int MAX_WORDS   = 8;
  localparam int WI_W        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WC_W        = $clog2(MAX_WORDS + 1);
  localparam int FI_W        = 2;
  localparam int LEN_W       = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_PATTERN = 2'd1,
    OP_BYTE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // pass flags and length of one finished packet
  typedef struct packed {
    logic [FILTERS-1:0] pass;
    logic [LEN_W-1:0]   len;
  } result_set_t;

endpackage

### rtl/masked_packet_filter_bank_core.sv
// Masked packet filter bank: one input transfer (table write or packet byte)
// per cycle. Byte compares run in a two-stage front end whose second stage
// reads each filter's own pattern memory; the last byte of a packet leaves a
// pass set in a two-entry queue, and the back end drains it at one result per
// cycle while result_ready holds, giving n results for n passing filters or
// one no-match result. Input stalls only while a last byte waits on a full
// queue. Depends on mpfb_pkg, mpfb_front, mpfb_queue and mpfb_back.
module masked_packet_filter_bank_core import mpfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  filter_index,
  input  logic [2:0]  word_index,
  input  logic [31:0] mask_word,
  input  logic [31:0] value_word,
  input  logic [13:0] word_offset,
  input  logic [3:0]  word_count,
  input  logic        pass_all,
  input  logic        inverted,
  input  logic        enabled,
  input  logic [7:0]  packet_byte,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  hit_filter,
  output logic        any_hit,
  output logic [15:0] packet_length,
  output logic        last_result
);

  logic        q_full;
  logic        push;
  result_set_t push_data;
  logic        pop;
  logic        head_valid;
  result_set_t head;

  mpfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .filter_index (filter_index),
    .word_index   (word_index),
    .mask_word    (mask_word),
    .value_word   (value_word),
    .word_offset  (word_offset),
    .word_count   (word_count),
    .pass_all     (pass_all),
    .inverted     (inverted),
    .enabled      (enabled),
    .packet_byte  (packet_byte),
    .last         (last),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  mpfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mpfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .hit_filter    (hit_filter),
    .any_hit       (any_hit),
    .packet_length (packet_length),
    .last_result   (last_result)
  );

endmodule

### rtl/mpfb_front.sv
// Front end: takes table writes and packet bytes, holds filter headers and
// pattern memories, checks bytes and produces one pass set per packet.
// Depends on mpfb_pkg.
module mpfb_front import mpfb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        op,
  input  logic [1:0]        filter_index,
  input  logic [2:0]        word_index,
  input  logic [31:0]       mask_word,
  input  logic [31:0]       value_word,
  input  logic [13:0]       word_offset,
  input  logic [3:0]        word_count,
  input  logic              pass_all,
  input  logic              inverted,
  input  logic              enabled,
  input  logic [7:0]        packet_byte,
  input  logic              last,
  input  logic              q_full,
  output logic              push,
  output result_set_t       push_data
);

  logic [FILTERS-1:0] filter_on;
  logic [FILTERS-1:0] filter_all;
  logic [FILTERS-1:0] filter_invert;
  logic [13:0]        window_start [FILTERS];
  logic [WC_W-1:0]    window_words [FILTERS];
  logic [FILTERS-1:0] mismatch_seen;
  logic [LEN_W-1:0]   byte_position;

  logic [31:0] pat_mask  [FILTERS][MAX_WORDS];
  logic [31:0] pat_value [FILTERS][MAX_WORDS];

  // second stage
  logic               b_valid;
  logic               b_last;
  logic [7:0]         b_byte;
  logic [LEN_W-1:0]   b_len;
  logic [FILTERS-1:0] b_inwin;
  logic [1:0]         b_lane [FILTERS];
  logic [31:0]        rd_mask  [FILTERS];
  logic [31:0]        rd_value [FILTERS];

  logic               stall;
  logic               take;
  logic               take_byte;
  logic               wr_hdr;
  logic               wr_pat;
  logic [LEN_W-1:0]   len_next;
  logic [FILTERS-1:0] inwin;
  logic [WI_W-1:0]    ridx [FILTERS];
  logic [1:0]         lane [FILTERS];
  logic [FILTERS-1:0] mm_now;
  logic [FILTERS-1:0] pass;
  logic [WC_W-1:0]    cnt_sat;

  assign stall      = b_valid & b_last & q_full;
  assign item_ready = ~stall;
  assign take       = item_valid & item_ready;
  assign take_byte  = take & (op == OP_BYTE);
  assign wr_hdr     = take & (op == OP_HEADER) & (32'(filter_index) < FILTERS);
  assign wr_pat     = take & (op == OP_PATTERN) & (32'(filter_index) < FILTERS)
                      & (32'(word_index) < MAX_WORDS);
  assign len_next   = (byte_position == {LEN_W{1'b1}}) ? byte_position
                                                       : byte_position + 1'b1;
  assign cnt_sat    = (32'(word_count) > MAX_WORDS) ? WC_W'(MAX_WORDS)
                                                    : WC_W'(word_count);

  always_comb begin
    logic [15:0] first;
    logic [16:0] lim;
    logic [15:0] rel;
    for (int f = 0; f < FILTERS; f++) begin
      first   = {window_start[f], 2'b00};
      lim     = 17'(first) + 17'({window_words[f], 2'b00});
      rel     = byte_position - first;
      inwin[f] = (byte_position >= first) && (17'(byte_position) < lim);
      ridx[f] = rel[WI_W+1:2];
      lane[f] = rel[1:0];
    end
  end

  always_comb begin
    logic [16:0] wend;
    logic        ok;
    for (int f = 0; f < FILTERS; f++) begin
      mm_now[f] = mismatch_seen[f] | (b_inwin[f] &
                  ((rd_mask[f][8*b_lane[f] +: 8] & b_byte) !=
                   rd_value[f][8*b_lane[f] +: 8]));
      wend    = 17'({window_start[f], 2'b00}) + 17'({window_words[f], 2'b00});
      ok      = (wend < 17'(b_len)) & (filter_all[f] | ~mm_now[f]);
      pass[f] = filter_on[f] & (ok ^ filter_invert[f]);
    end
  end

  assign push           = b_valid & b_last & ~q_full;
  assign push_data.pass = pass;
  assign push_data.len  = b_len;

  always_ff @(posedge clk) begin
    for (int f = 0; f < FILTERS; f++) begin
      if (wr_pat && 32'(filter_index) == f) begin
        pat_mask[f][WI_W'(word_index)]  <= mask_word;
        pat_value[f][WI_W'(word_index)] <= value_word;
      end
      if (!stall) begin
        rd_mask[f]  <= pat_mask[f][ridx[f]];
        rd_value[f] <= pat_value[f][ridx[f]];
        b_lane[f]   <= lane[f];
      end
    end
    if (!stall) begin
      b_last  <= last;
      b_byte  <= packet_byte;
      b_len   <= len_next;
      b_inwin <= inwin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_on     <= '0;
      filter_all    <= '0;
      filter_invert <= '0;
      mismatch_seen <= '0;
      byte_position <= '0;
      b_valid       <= 1'b0;
      for (int f = 0; f < FILTERS; f++) begin
        window_start[f] <= '0;
        window_words[f] <= '0;
      end
    end else begin
      if (wr_hdr) begin
        for (int f = 0; f < FILTERS; f++) begin
          if (32'(filter_index) == f) begin
            window_start[f]  <= word_offset;
            window_words[f]  <= cnt_sat;
            filter_all[f]    <= pass_all;
            filter_invert[f] <= inverted;
            filter_on[f]     <= enabled;
          end
        end
      end
      if (take_byte) begin
        byte_position <= last ? '0 : len_next;
      end
      if (!stall) begin
        b_valid <= take_byte;
        if (b_valid) begin
          mismatch_seen <= b_last ? '0 : mm_now;
        end
      end
    end
  end

endmodule

### rtl/mpfb_queue.sv
// Short queue of per-packet pass sets between front and back ends.
// Depends on mpfb_pkg.
module mpfb_queue import mpfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_set_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output result_set_t head
);

  result_set_t       entries [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QC_W-1:0]   count;

  assign full       = (32'(count) == QUEUE_DEPTH);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QC_W'(push) - QC_W'(pop);
    end
  end

endmodule

### rtl/mpfb_back.sv
// Back end: walks a packet's pass set and issues one result per transfer,
// lowest filter first, or a single no-match result.
// Depends on mpfb_pkg.
module mpfb_back import mpfb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  result_set_t       head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [1:0]        hit_filter,
  output logic              any_hit,
  output logic [15:0]       packet_length,
  output logic              last_result
);

  logic [FILTERS-1:0] served;
  logic [FILTERS-1:0] rem;
  logic [FILTERS-1:0] sel;
  logic [FI_W-1:0]    idx;
  logic               final_one;
  logic               load;

  assign rem       = head.pass & ~served;
  assign sel       = rem & (~rem + 1'b1);
  assign final_one = ((rem & ~sel) == '0);
  assign load      = head_valid & (~result_valid | result_ready);
  assign pop       = load & final_one;

  always_comb begin
    idx = '0;
    for (int i = FILTERS - 1; i >= 0; i--) begin
      if (rem[i]) idx = FI_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit_filter    <= idx;
      any_hit       <= (rem != '0);
      packet_length <= head.len;
      last_result   <= final_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      served       <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        served <= final_one ? '0 : (served | sel);
      end
    end
  end

endmodule
